### rtl/kfr_pkg.sv
// kfr_pkg: shared types and constants of the KISS frame receiver.
// Holds the receive mode and queue operation enums, the queue entry struct,
// the KISS special bytes, command codes, result kinds and table reset values.
package kfr_pkg;

  // Special bytes of the KISS framing
  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  // Command nibble of the type byte
  localparam logic [3:0] CMD_DATA    = 4'h0;
  localparam logic [3:0] CMD_TXDELAY = 4'h1;
  localparam logic [3:0] CMD_PERSIST = 4'h2;
  localparam logic [3:0] CMD_SLOT    = 4'h3;
  localparam logic [3:0] CMD_TXTAIL  = 4'h4;
  localparam logic [3:0] CMD_DUPLEX  = 4'h5;
  localparam logic [3:0] CMD_HW      = 4'h6;
  localparam logic [3:0] CMD_RETURN  = 4'hF;

  // Port nibble that is never served
  localparam logic [3:0] PORT_RESERVED = 4'hF;

  // Result kinds on the output channel
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_DATA_END = 3'd1;
  localparam logic [2:0] KIND_PARAM    = 3'd2;
  localparam logic [2:0] KIND_HW       = 3'd3;
  localparam logic [2:0] KIND_RETURN   = 3'd4;

  // Reset values of the per-port parameter tables
  localparam logic [7:0] TXDELAY_DEFAULT = 8'd50;
  localparam logic [7:0] PERSIST_DEFAULT = 8'd63;
  localparam logic [7:0] SLOT_DEFAULT    = 8'd10;
  localparam logic [7:0] TXTAIL_DEFAULT  = 8'd0;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRAME,
    MODE_ESC
  } rx_mode_e;

  typedef enum logic [2:0] {
    OP_DATA,
    OP_STAGE,
    OP_DATA_END,
    OP_PARAM,
    OP_HW_COMMIT,
    OP_RETURN
  } op_e;

  // One classified action, front to back. count carries the frame length,
  // the committed hardware length or the staging index, depending on op.
  typedef struct packed {
    op_e        op;
    logic [3:0] port;
    logic [3:0] cmd;
    logic [7:0] value;
    logic [9:0] count;
    logic       kiss;
  } op_entry_t;

endpackage

### rtl/kfr_front.sv
// kfr_front: byte classifier of the KISS frame receiver.
// Tracks framing, escaping, type byte and length; emits at most one op per byte.
// Depends on kfr_pkg.
module kfr_front #(
  parameter int MAX_FRAME_BYTES = 512,
  parameter int NUM_PORTS       = 16,
  parameter int HW_BYTES        = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 push_o,
  output kfr_pkg::op_entry_t   entry_o
);

  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);

  kfr_pkg::rx_mode_e mode_q, mode_d;
  logic              seen_q, seen_d;
  logic [7:0]        type_q, type_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              gap_q, gap_d;
  logic              kiss_q, kiss_d;
  logic [7:0]        first_q, first_d;

  logic        enter, gap_ev, c0_ev, close_ev, to_esc, take;
  logic [7:0]  take_byte;
  logic        take_type, take_pay, pay_ok, usable;
  logic [3:0]  port, cmd;
  logic [31:0] count_w, hw_n;

  assign port    = type_q[7:4];
  assign cmd     = type_q[3:0];
  assign usable  = (port != kfr_pkg::PORT_RESERVED) && ({1'b0, port} < 5'(NUM_PORTS));
  assign count_w = 32'(count_q);
  assign pay_ok  = count_w < 32'(MAX_FRAME_BYTES);
  assign hw_n    = (count_w > 32'(HW_BYTES)) ? 32'(HW_BYTES) : count_w;

  // Decode the byte against the current mode
  always_comb begin
    enter     = 1'b0;
    gap_ev    = 1'b0;
    c0_ev     = 1'b0;
    close_ev  = 1'b0;
    to_esc    = 1'b0;
    take      = 1'b0;
    take_byte = rx_byte_i;
    case (mode_q)
      kfr_pkg::MODE_IDLE: begin
        enter = (rx_byte_i == kfr_pkg::FEND);
      end
      kfr_pkg::MODE_FRAME: begin
        if (rx_byte_i == kfr_pkg::FEND) begin
          if (!seen_q) begin
            gap_ev = gap_q;
            c0_ev  = !gap_q;
          end else begin
            close_ev = 1'b1;
          end
        end else if (rx_byte_i == kfr_pkg::FESC) begin
          to_esc = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      kfr_pkg::MODE_ESC: begin
        if (rx_byte_i == kfr_pkg::TFEND) begin
          take      = 1'b1;
          take_byte = kfr_pkg::FEND;
        end else if (rx_byte_i == kfr_pkg::TFESC) begin
          take      = 1'b1;
          take_byte = kfr_pkg::FESC;
        end
      end
      default: ;
    endcase
  end

  assign take_type = take && !seen_q;
  assign take_pay  = take && seen_q;

  // Next state
  always_comb begin
    mode_d  = mode_q;
    seen_d  = seen_q;
    type_d  = type_q;
    count_d = count_q;
    gap_d   = gap_q;
    kiss_d  = kiss_q;
    first_d = first_q;
    if (fire_i) begin
      if (enter) begin
        mode_d  = kfr_pkg::MODE_FRAME;
        count_d = '0;
        seen_d  = 1'b0;
        type_d  = '0;
        kiss_d  = 1'b1;
        gap_d   = 1'b0;
      end
      if (to_esc) begin
        mode_d = kfr_pkg::MODE_ESC;
      end
      if (mode_q == kfr_pkg::MODE_ESC) begin
        mode_d = kfr_pkg::MODE_FRAME;
      end
      if (gap_ev) begin
        count_d = '0;
        gap_d   = 1'b0;
      end
      if (c0_ev) begin
        type_d = kfr_pkg::FEND;
        seen_d = 1'b1;
      end
      if (take_type) begin
        type_d = take_byte;
        seen_d = 1'b1;
        gap_d  = 1'b0;
      end
      if (take_pay && pay_ok) begin
        count_d = count_q + 1'b1;
        if (count_q == '0) begin
          first_d = take_byte;
        end
      end
      if (close_ev) begin
        count_d = '0;
        seen_d  = 1'b0;
        type_d  = '0;
        gap_d   = 1'b1;
        if (cmd == kfr_pkg::CMD_RETURN) begin
          kiss_d = 1'b0;
        end
      end
    end
  end

  // Op generation
  always_comb begin
    push_o        = 1'b0;
    entry_o.op    = kfr_pkg::OP_DATA;
    entry_o.port  = port;
    entry_o.cmd   = cmd;
    entry_o.value = '0;
    entry_o.count = '0;
    entry_o.kiss  = kiss_q;
    if (take_pay && pay_ok) begin
      if (cmd == kfr_pkg::CMD_DATA && usable) begin
        push_o        = fire_i;
        entry_o.op    = kfr_pkg::OP_DATA;
        entry_o.value = take_byte;
      end else if (cmd == kfr_pkg::CMD_HW && usable && count_w < 32'(HW_BYTES)) begin
        push_o        = fire_i;
        entry_o.op    = kfr_pkg::OP_STAGE;
        entry_o.value = take_byte;
        entry_o.count = 10'(count_q);
      end
    end
    if (close_ev) begin
      if (cmd == kfr_pkg::CMD_RETURN) begin
        push_o       = fire_i;
        entry_o.op   = kfr_pkg::OP_RETURN;
        entry_o.kiss = 1'b0;
      end else if (usable) begin
        case (cmd)
          kfr_pkg::CMD_DATA: begin
            push_o        = fire_i && (count_q != '0);
            entry_o.op    = kfr_pkg::OP_DATA_END;
            entry_o.count = 10'(count_q);
          end
          kfr_pkg::CMD_TXDELAY, kfr_pkg::CMD_PERSIST, kfr_pkg::CMD_SLOT,
          kfr_pkg::CMD_TXTAIL, kfr_pkg::CMD_DUPLEX: begin
            push_o        = fire_i && (count_q != '0);
            entry_o.op    = kfr_pkg::OP_PARAM;
            entry_o.value = first_q;
          end
          kfr_pkg::CMD_HW: begin
            push_o        = fire_i;
            entry_o.op    = kfr_pkg::OP_HW_COMMIT;
            entry_o.count = 10'(hw_n);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= kfr_pkg::MODE_IDLE;
      seen_q  <= 1'b0;
      type_q  <= '0;
      count_q <= '0;
      gap_q   <= 1'b0;
      kiss_q  <= 1'b0;
      first_q <= '0;
    end else begin
      mode_q  <= mode_d;
      seen_q  <= seen_d;
      type_q  <= type_d;
      count_q <= count_d;
      gap_q   <= gap_d;
      kiss_q  <= kiss_d;
      first_q <= first_d;
    end
  end

endmodule

### rtl/kfr_queue.sv
// kfr_queue: two-entry op queue between front and back.
// Depends on kfr_pkg for the entry type.
module kfr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  kfr_pkg::op_entry_t push_entry_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output kfr_pkg::op_entry_t entry_o
);

  kfr_pkg::op_entry_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

### rtl/kfr_back.sv
// kfr_back: executes queued ops, updates the per-port tables and the
// hardware store, and holds the result register. Depends on kfr_pkg.
module kfr_back #(
  parameter int NUM_PORTS = 16,
  parameter int HW_BYTES  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  kfr_pkg::op_entry_t q_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         result_kind_o,
  output logic [3:0]         port_number_o,
  output logic [3:0]         command_code_o,
  output logic [7:0]         byte_value_o,
  output logic [9:0]         byte_count_o,
  output logic               kiss_mode_on_o
);

  localparam int PortW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int IdxW   = (HW_BYTES > 1) ? $clog2(HW_BYTES) : 1;
  localparam int HwLenW = $clog2(HW_BYTES + 1);
  localparam int AddrW  = PortW + 1 + IdxW;

  logic [7:0]        txdelay_q [NUM_PORTS];
  logic [7:0]        persist_q [NUM_PORTS];
  logic [7:0]        slot_q    [NUM_PORTS];
  logic [7:0]        txtail_q  [NUM_PORTS];
  logic              duplex_q  [NUM_PORTS];
  logic [HwLenW-1:0] hw_len_q  [NUM_PORTS];
  logic              bank_q    [NUM_PORTS];
  logic [7:0]        hw_mem    [2**AddrW];

  logic             out_valid_q, out_valid_d;
  logic [2:0]       kind_q, kind_d;
  logic [3:0]       port_q, cmd_q;
  logic [7:0]       value_q, value_d;
  logic [9:0]       count_q;
  logic             kiss_q;
  logic             produces;
  logic [PortW-1:0] pidx;
  logic [7:0]       param_val;

  assign pidx      = q_entry_i.port[PortW-1:0];
  assign pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign produces  = (q_entry_i.op != kfr_pkg::OP_STAGE);
  assign param_val = (q_entry_i.cmd == kfr_pkg::CMD_DUPLEX)
                     ? {7'd0, q_entry_i.value != 8'd0} : q_entry_i.value;

  always_comb begin
    kind_d  = kfr_pkg::KIND_DATA;
    value_d = q_entry_i.value;
    case (q_entry_i.op)
      kfr_pkg::OP_DATA:      kind_d = kfr_pkg::KIND_DATA;
      kfr_pkg::OP_DATA_END:  kind_d = kfr_pkg::KIND_DATA_END;
      kfr_pkg::OP_PARAM: begin
        kind_d  = kfr_pkg::KIND_PARAM;
        value_d = param_val;
      end
      kfr_pkg::OP_HW_COMMIT: kind_d = kfr_pkg::KIND_HW;
      kfr_pkg::OP_RETURN:    kind_d = kfr_pkg::KIND_RETURN;
      default:               kind_d = kfr_pkg::KIND_DATA;
    endcase
  end

  // Hold the result until taken; load a new one only when the slot frees
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o && produces) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && produces) begin
      kind_q  <= kind_d;
      port_q  <= q_entry_i.port;
      cmd_q   <= q_entry_i.cmd;
      value_q <= value_d;
      count_q <= q_entry_i.count;
      kiss_q  <= q_entry_i.kiss;
    end
  end

  // Stage hardware bytes into the bank that is not live; commit flips it
  always_ff @(posedge clk_i) begin
    if (pop_o && q_entry_i.op == kfr_pkg::OP_STAGE) begin
      hw_mem[{pidx, !bank_q[pidx], q_entry_i.count[IdxW-1:0]}] <= q_entry_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        txdelay_q[p] <= kfr_pkg::TXDELAY_DEFAULT;
        persist_q[p] <= kfr_pkg::PERSIST_DEFAULT;
        slot_q[p]    <= kfr_pkg::SLOT_DEFAULT;
        txtail_q[p]  <= kfr_pkg::TXTAIL_DEFAULT;
        duplex_q[p]  <= 1'b0;
        hw_len_q[p]  <= '0;
        bank_q[p]    <= 1'b0;
      end
    end else if (pop_o) begin
      if (q_entry_i.op == kfr_pkg::OP_PARAM) begin
        case (q_entry_i.cmd)
          kfr_pkg::CMD_TXDELAY: txdelay_q[pidx] <= param_val;
          kfr_pkg::CMD_PERSIST: persist_q[pidx] <= param_val;
          kfr_pkg::CMD_SLOT:    slot_q[pidx]    <= param_val;
          kfr_pkg::CMD_TXTAIL:  txtail_q[pidx]  <= param_val;
          kfr_pkg::CMD_DUPLEX:  duplex_q[pidx]  <= param_val[0];
          default: ;
        endcase
      end
      if (q_entry_i.op == kfr_pkg::OP_HW_COMMIT) begin
        bank_q[pidx]   <= !bank_q[pidx];
        hw_len_q[pidx] <= q_entry_i.count[HwLenW-1:0];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign port_number_o  = port_q;
  assign command_code_o = cmd_q;
  assign byte_value_o   = (kind_q == kfr_pkg::KIND_DATA || kind_q == kfr_pkg::KIND_PARAM)
                          ? value_q : 8'd0;
  assign byte_count_o   = (kind_q == kfr_pkg::KIND_DATA_END || kind_q == kfr_pkg::KIND_HW)
                          ? count_q : 10'd0;
  assign kiss_mode_on_o = kiss_q;

endmodule

### rtl/kiss_frame_receiver_top.sv
// kiss_frame_receiver_top: KISS receive deframer, one serial byte per beat.
// Instantiates kfr_front, kfr_queue and kfr_back; depends on kfr_pkg.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   input    | in_valid_i/in_ready_o | rx_byte_i
//   output   | out_valid_o/          | result_kind_o, port_number_o,
//            |   out_ready_i         | command_code_o, byte_value_o,
//            |                       | byte_count_o, kiss_mode_on_o
//
// Rate: one input beat per cycle while the queue has room; a result goes from
//   its byte through front decision, queue slot and result register.
// The front updates framing state in the cycle the byte is taken and pushes at
//   most one op into a two-entry queue; the back runs one op a cycle if free.
// Stalls: out_ready_i low holds the result register; the queue then fills
//   and in_ready_o drops when both entries are taken.
// Reset: asynchronous, clears framing state, queue, result valid and the
//   per-port tables to their defaults. The hardware store needs no clear.
module kiss_frame_receiver_top #(
  parameter int MAX_FRAME_BYTES = 512,
  parameter int NUM_PORTS       = 16,
  parameter int HW_BYTES        = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] result_kind_o,
  output logic [3:0] port_number_o,
  output logic [3:0] command_code_o,
  output logic [7:0] byte_value_o,
  output logic [9:0] byte_count_o,
  output logic       kiss_mode_on_o
);

  logic               fire;
  logic               push, full, q_valid, pop;
  kfr_pkg::op_entry_t push_entry, q_entry;

  // Take a byte whenever the queue has room, even if it yields no op
  assign in_ready_o = !full;
  assign fire       = in_valid_i && in_ready_o;

  kfr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .NUM_PORTS      (NUM_PORTS),
    .HW_BYTES       (HW_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  kfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .entry_o     (q_entry)
  );

  kfr_back #(
    .NUM_PORTS(NUM_PORTS),
    .HW_BYTES (HW_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .port_number_o (port_number_o),
    .command_code_o(command_code_o),
    .byte_value_o  (byte_value_o),
    .byte_count_o  (byte_count_o),
    .kiss_mode_on_o(kiss_mode_on_o)
  );

endmodule

### rtl/kfr_checker.sv
// kfr_checker: port-level assertions for kiss_frame_receiver_top, with bind.
// Depends on kfr_pkg for result kind codes.
module kfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] result_kind_o,
  input logic [3:0] command_code_o,
  input logic [7:0] byte_value_o,
  input logic [9:0] byte_count_o,
  input logic       kiss_mode_on_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(byte_value_o) && $stable(byte_count_o))
    else $error("result changed while stalled");

  a_return_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == kfr_pkg::KIND_RETURN
      |-> !kiss_mode_on_o && command_code_o == kfr_pkg::CMD_RETURN)
    else $error("return result with KISS mode still on");

  a_data_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == kfr_pkg::KIND_DATA
      |-> byte_count_o == 10'd0 && command_code_o == kfr_pkg::CMD_DATA)
    else $error("data byte result malformed");

  a_end_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == kfr_pkg::KIND_DATA_END
      |-> byte_count_o != 10'd0 && byte_value_o == 8'd0)
    else $error("empty or malformed frame end");

endmodule

bind kiss_frame_receiver_top kfr_checker u_kfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .command_code_o(command_code_o),
  .byte_value_o  (byte_value_o),
  .byte_count_o  (byte_count_o),
  .kiss_mode_on_o(kiss_mode_on_o)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for kiss_frame_receiver_top, the KISS deframer.
// Depends on kfr_pkg and the RTL top; a built-in predictor checks every result beat.
module testbench;

  // Block configuration, matching the instance below
  localparam int MAX_FRAME_BYTES = 512;
  localparam int NUM_PORTS       = 16;
  localparam int HW_BYTES        = 16;

  // Run control
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_BEATS  = 225;

  typedef logic [7:0] byte_list_t[$];

  // One deframed result, field for field as on the output ports
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] port;
    logic [3:0] cmd;
    logic [7:0] value;
    logic [9:0] count;
    logic       kiss;
  } deframed_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] result_kind_o;
  logic [3:0] port_number_o;
  logic [3:0] command_code_o;
  logic [7:0] byte_value_o;
  logic [9:0] byte_count_o;
  logic       kiss_mode_on_o;

  kiss_frame_receiver_top #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .NUM_PORTS      (NUM_PORTS),
    .HW_BYTES       (HW_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .port_number_o (port_number_o),
    .command_code_o(command_code_o),
    .byte_value_o  (byte_value_o),
    .byte_count_o  (byte_count_o),
    .kiss_mode_on_o(kiss_mode_on_o)
  );

  // Pending results in arrival order, and run bookkeeping
  deframed_t   pending_results[$];
  int          error_count   = 0;
  int          beats_sent    = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Deframer state mirrored from the block's behavior
  kfr_pkg::rx_mode_e mode_q = kfr_pkg::MODE_IDLE;
  logic        type_seen_q  = 1'b0;
  logic [7:0]  type_q       = 8'h00;
  int unsigned length_q     = 0;
  logic        gap_q        = 1'b0;
  logic        kiss_q       = 1'b0;
  logic [7:0]  first_byte_q = 8'h00;
  logic [7:0]  param_table [NUM_PORTS][kfr_pkg::CMD_DUPLEX];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort the run when it stalls far beyond any legal duration
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  function automatic bit port_served(logic [3:0] port);
    return port != kfr_pkg::PORT_RESERVED && int'(port) < NUM_PORTS;
  endfunction

  // Queue one result; port, command and mode flag come from the current frame
  function automatic void push_result(logic [2:0] kind, logic [7:0] value, int unsigned count);
    deframed_t r;
    r.kind  = kind;
    r.port  = type_q[7:4];
    r.cmd   = type_q[3:0];
    r.value = value;
    r.count = count[9:0];
    r.kiss  = kiss_q;
    pending_results.push_back(r);
  endfunction

  function automatic void take_type_byte(logic [7:0] b);
    type_q      = b;
    type_seen_q = 1'b1;
    gap_q       = 1'b0;
  endfunction

  // Count a payload byte; stream it when the frame is DATA on a served port
  function automatic void take_payload_byte(logic [7:0] b);
    if (length_q >= MAX_FRAME_BYTES) return;
    if (length_q == 0) first_byte_q = b;
    length_q++;
    if (type_q[3:0] == kfr_pkg::CMD_DATA && port_served(type_q[7:4]))
      push_result(kfr_pkg::KIND_DATA, b, 0);
  endfunction

  // Closing FEND of a frame with a type byte
  function automatic void close_frame();
    logic [3:0]  port;
    logic [3:0]  cmd;
    logic [7:0]  stored;
    int unsigned hw_len;
    port = type_q[7:4];
    cmd  = type_q[3:0];
    if (cmd == kfr_pkg::CMD_RETURN) begin
      kiss_q = 1'b0;
      push_result(kfr_pkg::KIND_RETURN, 8'h00, 0);
      return;
    end
    if (!port_served(port)) return;
    case (cmd)
      kfr_pkg::CMD_DATA: begin
        if (length_q > 0) push_result(kfr_pkg::KIND_DATA_END, 8'h00, length_q);
      end
      kfr_pkg::CMD_TXDELAY, kfr_pkg::CMD_PERSIST, kfr_pkg::CMD_SLOT,
      kfr_pkg::CMD_TXTAIL, kfr_pkg::CMD_DUPLEX: begin
        if (length_q > 0) begin
          stored = (cmd == kfr_pkg::CMD_DUPLEX) ? {7'd0, first_byte_q != 8'h00}
                                                : first_byte_q;
          param_table[port][cmd - 1] = stored;
          push_result(kfr_pkg::KIND_PARAM, stored, 0);
        end
      end
      kfr_pkg::CMD_HW: begin
        hw_len = (length_q > HW_BYTES) ? HW_BYTES : length_q;
        push_result(kfr_pkg::KIND_HW, 8'h00, hw_len);
      end
      default: ;
    endcase
  endfunction

  // Advance the mirrored deframer by one accepted byte
  function automatic void predict_byte(logic [7:0] b);
    case (mode_q)
      kfr_pkg::MODE_IDLE: begin
        if (b == kfr_pkg::FEND) begin
          length_q    = 0;
          type_seen_q = 1'b0;
          type_q      = 8'h00;
          mode_q      = kfr_pkg::MODE_FRAME;
          kiss_q      = 1'b1;
          gap_q       = 1'b0;
        end
      end
      kfr_pkg::MODE_FRAME: begin
        if (b == kfr_pkg::FEND) begin
          if (!type_seen_q) begin
            // A FEND right after a close is the gap; otherwise it is type C0
            if (gap_q) begin
              length_q = 0;
              gap_q    = 1'b0;
            end else begin
              type_q      = kfr_pkg::FEND;
              type_seen_q = 1'b1;
            end
          end else begin
            close_frame();
            length_q    = 0;
            type_seen_q = 1'b0;
            type_q      = 8'h00;
            gap_q       = 1'b1;
          end
        end else if (b == kfr_pkg::FESC) begin
          mode_q = kfr_pkg::MODE_ESC;
        end else if (!type_seen_q) begin
          take_type_byte(b);
        end else begin
          take_payload_byte(b);
        end
      end
      default: begin
        // Escaped byte: unescape TFEND/TFESC, drop anything else with the FESC
        mode_q = kfr_pkg::MODE_FRAME;
        if (b == kfr_pkg::TFEND || b == kfr_pkg::TFESC) begin
          if (!type_seen_q)
            take_type_byte(b == kfr_pkg::TFEND ? kfr_pkg::FEND : kfr_pkg::FESC);
          else
            take_payload_byte(b == kfr_pkg::TFEND ? kfr_pkg::FEND : kfr_pkg::FESC);
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Result side: random backpressure and the scoreboard
  // ------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(string name, int unsigned expected, int unsigned actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // Compare every accepted result beat with the oldest pending result
  always @(posedge clk_i) begin
    deframed_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: kind %0d port %0d cmd %0d", result_kind_o,
               port_number_o, command_code_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("result_kind", exp_r.kind, result_kind_o);
        check_field("port_number", exp_r.port, port_number_o);
        check_field("command_code", exp_r.cmd, command_code_o);
        check_field("byte_value", exp_r.value, byte_value_o);
        check_field("byte_count", exp_r.count, byte_count_o);
        check_field("kiss_mode_on", exp_r.kiss, kiss_mode_on_o);
      end
    end
  end

  // ------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------

  // Send one byte beat; entered and left at a falling edge
  task automatic send_beat(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Send a byte with KISS escaping of FEND and FESC
  task automatic send_escaped(logic [7:0] b);
    if (b == kfr_pkg::FEND) begin
      send_beat(kfr_pkg::FESC);
      send_beat(kfr_pkg::TFEND);
    end else if (b == kfr_pkg::FESC) begin
      send_beat(kfr_pkg::FESC);
      send_beat(kfr_pkg::TFESC);
    end else begin
      send_beat(b);
    end
  endtask

  // Send a whole frame: optional opening FEND, type byte, payload, closing FEND
  task automatic send_frame(logic [7:0] frame_type, byte_list_t payload, bit lead);
    if (lead) send_beat(kfr_pkg::FEND);
    send_escaped(frame_type);
    foreach (payload[i]) send_escaped(payload[i]);
    send_beat(kfr_pkg::FEND);
  endtask

  // Payload byte biased toward the framing specials
  function automatic logic [7:0] random_payload_byte();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return kfr_pkg::FEND;
        1:       return kfr_pkg::FESC;
        2:       return kfr_pkg::TFEND;
        default: return kfr_pkg::TFESC;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Drop line noise while idle, then open KISS mode with a FEND
  task automatic test_idle_bytes();
    send_beat(8'h00);
    send_beat(8'hFF);
    send_beat(kfr_pkg::FESC);
    send_beat(kfr_pkg::TFEND);
    send_beat(kfr_pkg::FEND);
  endtask

  // DATA frames with extreme and escaped payload bytes, plus an empty one
  task automatic test_data_frames();
    byte_list_t pl;
    pl = '{8'h00, 8'hFF, kfr_pkg::FEND, kfr_pkg::FESC, kfr_pkg::TFEND, kfr_pkg::TFESC};
    send_frame(8'h00, pl, 1'b0);
    pl = '{8'h5A};
    send_frame(8'hE0, pl, 1'b1);
    pl = '{};
    send_frame(8'h20, pl, 1'b1);
  endtask

  // Doubled FEND after the gap, and an escaped FEND, both give type C0
  task automatic test_port12_type();
    byte_list_t pl;
    send_beat(kfr_pkg::FEND);
    send_beat(kfr_pkg::FEND);
    send_beat(8'h11);
    send_beat(8'h22);
    send_beat(kfr_pkg::FEND);
    pl = '{8'h33};
    send_frame(kfr_pkg::FEND, pl, 1'b1);
    // Escaped FESC as type: port 13 with an unknown command, so nothing comes out
    send_frame(kfr_pkg::FESC, pl, 1'b1);
  endtask

  // Bad escapes drop both bytes, in the payload and in the type position
  task automatic test_bad_escape();
    send_beat(kfr_pkg::FEND);
    send_beat(8'h30);
    send_beat(8'h01);
    send_beat(kfr_pkg::FESC);
    send_beat(8'h41);
    send_beat(8'h02);
    send_beat(kfr_pkg::FEND);
    send_beat(kfr_pkg::FEND);
    send_beat(kfr_pkg::FESC);
    send_beat(8'h00);
    send_beat(8'h40);
    send_beat(8'h7E);
    send_beat(kfr_pkg::FEND);
  endtask

  // Every parameter command at both value extremes, duplex nonzero, an empty frame
  task automatic test_parameter_commands();
    byte_list_t pl;
    logic [3:0] cmd;
    for (int c = int'(kfr_pkg::CMD_TXDELAY); c <= int'(kfr_pkg::CMD_DUPLEX); c++) begin
      cmd = 4'(c);
      pl = '{8'hFF, 8'h12};
      send_frame({4'(c), cmd}, pl, 1'b1);
      pl = '{8'h00};
      send_frame({4'hE, cmd}, pl, 1'b1);
    end
    pl = '{8'h80};
    send_frame({4'h2, kfr_pkg::CMD_DUPLEX}, pl, 1'b1);
    pl = '{};
    send_frame({4'h1, kfr_pkg::CMD_TXDELAY}, pl, 1'b1);
  endtask

  // SetHardware with no bytes, a few bytes and more than the store holds
  task automatic test_hardware_frames();
    byte_list_t pl;
    pl = '{};
    send_frame({4'h3, kfr_pkg::CMD_HW}, pl, 1'b1);
    pl = '{8'h01, kfr_pkg::FEND, 8'h03, kfr_pkg::FESC, 8'hFF};
    send_frame({4'h0, kfr_pkg::CMD_HW}, pl, 1'b1);
    pl = '{};
    repeat (HW_BYTES + 4) pl.push_back(8'($urandom_range(255)));
    send_frame({4'hE, kfr_pkg::CMD_HW}, pl, 1'b1);
  endtask

  // Reserved port and unknown commands give nothing
  task automatic test_ignored_frames();
    byte_list_t pl;
    pl = '{8'hAA, 8'h55};
    send_frame({kfr_pkg::PORT_RESERVED, kfr_pkg::CMD_DATA}, pl, 1'b1);
    send_frame({kfr_pkg::PORT_RESERVED, kfr_pkg::CMD_TXDELAY}, pl, 1'b1);
    send_frame({kfr_pkg::PORT_RESERVED, kfr_pkg::CMD_HW}, pl, 1'b1);
    send_frame(8'h77, pl, 1'b1);
    send_frame(8'h1E, pl, 1'b1);
  endtask

  // Payload past the frame limit is dropped and the length saturates
  task automatic test_oversize_frame();
    byte_list_t pl;
    pl = '{};
    repeat (MAX_FRAME_BYTES + 6) pl.push_back(8'($urandom_range(255)));
    send_frame({4'h1, kfr_pkg::CMD_DATA}, pl, 1'b1);
  endtask

  // RETURN works on any port, including the reserved one, and clears KISS mode
  task automatic test_return_command();
    byte_list_t pl;
    pl = '{8'h99};
    send_frame({kfr_pkg::PORT_RESERVED, kfr_pkg::CMD_RETURN}, pl, 1'b1);
    pl = '{};
    send_frame({4'h0, kfr_pkg::CMD_RETURN}, pl, 1'b1);
    pl = '{8'h44};
    send_frame({4'h0, kfr_pkg::CMD_DATA}, pl, 1'b1);
  endtask

  // One random frame, or a short burst of raw noise
  task automatic random_frame();
    byte_list_t pl;
    logic [3:0] port;
    logic [3:0] cmd;
    int         sel;
    int         len;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4)) send_beat(random_payload_byte());
      return;
    end
    port = ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    sel  = $urandom_range(99);
    if (sel < 50)      cmd = kfr_pkg::CMD_DATA;
    else if (sel < 74)
      cmd = 4'($urandom_range(int'(kfr_pkg::CMD_TXDELAY), int'(kfr_pkg::CMD_DUPLEX)));
    else if (sel < 86) cmd = kfr_pkg::CMD_HW;
    else if (sel < 98) cmd = 4'($urandom_range(7, 14));
    else               cmd = kfr_pkg::CMD_RETURN;
    if (cmd == kfr_pkg::CMD_DATA)
      len = ($urandom_range(99) < 5) ? $urandom_range(13, 40) : $urandom_range(12);
    else if (cmd == kfr_pkg::CMD_HW)
      len = $urandom_range(HW_BYTES + 4);
    else
      len = $urandom_range(3);
    pl = '{};
    repeat (len) pl.push_back(random_payload_byte());
    send_frame({port, cmd}, pl, $urandom_range(99) < 80);
  endtask

  // Random traffic in phases of sender idling and receiver stalling
  task automatic test_random_traffic();
    int idle_pct [4];
    int stall_pct[4];
    int target;
    idle_pct  = '{0, 75, 0, 10};
    stall_pct = '{0, 0, 75, 10};
    foreach (idle_pct[p]) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) random_frame();
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      param_table[p][0] = kfr_pkg::TXDELAY_DEFAULT;
      param_table[p][1] = kfr_pkg::PERSIST_DEFAULT;
      param_table[p][2] = kfr_pkg::SLOT_DEFAULT;
      param_table[p][3] = kfr_pkg::TXTAIL_DEFAULT;
      param_table[p][4] = 8'h00;
    end

    // Hold reset, then release it on a falling edge
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    test_idle_bytes();
    test_data_frames();
    test_port12_type();
    test_bad_escape();
    test_parameter_commands();
    test_hardware_frames();
    test_ignored_frames();
    test_oversize_frame();
    test_return_command();
    test_random_traffic();

    // Drop valid, drain the results, then watch for strays
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    wait (pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
